// File: hw/rtl/vkit_pkg.sv
// Shared types for the variant key interning table.
// Item structs, key width and controller/datapath command and status groups.
// No dependencies.
`default_nettype none

package vkit_pkg;

    localparam int KEY_W    = 144;
    localparam int HANDLE_W = 8;

    typedef struct packed {
        logic [31:0] technique_id;
        logic [31:0] definition_id;
        logic [63:0] feature_hash;
        logic [7:0]  phase_id;
        logic [7:0]  tier_id;
    } vkit_in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                created;
        logic                table_full;
    } vkit_out_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch key, restart the scan
        logic scan_en;   // issue reads / compare
        logic finish;    // resolve hit, insert or full into the result
        logic load_out;  // move the result into the output register
    } vkit_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // compared entry equals the key
        logic exhausted; // every stored entry compared, none equal
        logic out_free;  // output register can take a result
    } vkit_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/vkit_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vkit_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vkit_dp.sv
// Datapath: key register, key store RAM, scan pipeline, entry count,
// result and output registers. Depends on vkit_pkg and vkit_ram.
`default_nettype none

module vkit_dp #(
    parameter int CAPACITY = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire vkit_pkg::vkit_in_t   s_data,
    input  wire vkit_pkg::vkit_cmd_t  cmd,
    output vkit_pkg::vkit_stat_t      stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output vkit_pkg::vkit_out_t       m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [vkit_pkg::KEY_W-1:0] key_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              issue_idx_reg, issue_idx_next;
    logic [CW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    vkit_pkg::vkit_out_t        res_reg, res_next;
    vkit_pkg::vkit_out_t        out_reg;
    logic                       out_valid_reg, out_valid_next;

    logic                       issue;
    logic                       match;
    logic                       is_full;
    logic                       do_insert;
    logic [vkit_pkg::KEY_W-1:0] rd_data;

    assign issue     = cmd.scan_en && !cmd.start && (issue_idx_reg < count_reg);
    assign match     = cmp_valid_reg && (rd_data == key_reg);
    assign is_full   = (count_reg == CAP_C);
    assign do_insert = cmd.finish && !match && !is_full;

    vkit_ram #(
        .WIDTH (vkit_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (do_insert),
        .waddr (count_reg[AW-1:0]),
        .wdata (key_reg),
        .re    (issue),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        issue_idx_next = issue_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = issue;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (cmd.start) begin
            issue_idx_next = '0;
        end else if (issue) begin
            issue_idx_next = issue_idx_reg + 1'b1;
            cmp_idx_next   = issue_idx_reg;
        end

        if (cmd.finish) begin
            if (match) begin
                res_next.handle     = vkit_pkg::HANDLE_W'(cmp_idx_reg);
                res_next.created    = 1'b0;
                res_next.table_full = 1'b0;
            end else if (is_full) begin
                res_next.handle     = '0;
                res_next.created    = 1'b0;
                res_next.table_full = 1'b1;
            end else begin
                res_next.handle     = vkit_pkg::HANDLE_W'(count_reg);
                res_next.created    = 1'b1;
                res_next.table_full = 1'b0;
                count_next          = count_reg + 1'b1;
            end
        end

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (cmd.start) begin
            key_reg <= s_data;
        end
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign stat.hit       = match;
    assign stat.exhausted = !cmp_valid_reg && (issue_idx_reg == count_reg);
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        match |-> (cmp_idx_reg < count_reg))
        else $error("hit on an entry never stored");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the entry count");

    a_out_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.created && out_reg.table_full))
        else $error("result both created and full");

    a_finish_resolved: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (match || (!cmp_valid_reg && issue_idx_reg == count_reg)))
        else $error("finish before the scan resolved");

endmodule

`default_nettype wire

// File: hw/rtl/vkit_ctrl.sv
// Controller: sequences accept, scan, resolve and hand-off of one item.
// Depends on vkit_pkg.
`default_nettype none

module vkit_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire vkit_pkg::vkit_stat_t stat,
    output vkit_pkg::vkit_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        cmd.start    = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.finish   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                    ready_next = 1'b0;
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.hit || stat.exhausted) begin
                    cmd.finish = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                    ready_next   = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

// File: hw/rtl/variant_key_interning_table_unit.sv
// Top level of the variant key interning table.
// Depends on vkit_pkg, vkit_ctrl, vkit_dp (and vkit_ram below it).
//
//  channel | ports                      | payload
//  --------+----------------------------+----------------------------------
//  in      | s_valid, s_ready, s_data   | vkit_in_t: five key parts
//  out     | m_valid, m_ready, m_data   | vkit_out_t: handle, created, full
//
// One item at a time. With N keys stored, a hit on entry i resolves once entries
// 0..i are compared, a miss once all N are compared (no reads on an empty table);
// the scan reads one stored key per cycle through the key RAM's read port.
// s_ready drops on accept and rises with m_valid, so the next item may enter
// while that result is not yet taken; it then waits until the output is free.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module variant_key_interning_table_unit #(
    parameter int CAPACITY = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vkit_pkg::vkit_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vkit_pkg::vkit_out_t      m_data
);

    vkit_pkg::vkit_cmd_t  cmd;
    vkit_pkg::vkit_stat_t stat;

    vkit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vkit_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: tb/tb_variant_key_interning_table_unit.sv
// Self-checking testbench for variant_key_interning_table_unit.
// Drives composite keys, predicts handle/created/full in a scoreboard class.
// Depends on vkit_pkg and the RTL under hw/rtl.
`default_nettype none

module tb_variant_key_interning_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 256;
    localparam int ITEMS        = 600;
    localparam int QUIET_TAIL   = 80;
    localparam int FULL_ITEMS   = 60;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = SLOTS + 40;
    localparam int REPORT_MAX   = 10;

    class intern_scoreboard;
        vkit_pkg::vkit_in_t  slot_key[SLOTS];
        int                  slot_count;
        vkit_pkg::vkit_out_t expected_results[$];
        int                  mismatches;

        // Linear search in insertion order; a miss claims the next slot if any is free.
        function vkit_pkg::vkit_out_t intern_key(vkit_pkg::vkit_in_t k);
            vkit_pkg::vkit_out_t r;
            r = '0;
            for (int i = 0; i < slot_count; i++) begin
                if (slot_key[i] == k) begin
                    r.handle = i[vkit_pkg::HANDLE_W-1:0];
                    return r;
                end
            end
            if (slot_count >= SLOTS) begin
                r.table_full = 1'b1;
                return r;
            end
            slot_key[slot_count] = k;
            r.handle  = slot_count[vkit_pkg::HANDLE_W-1:0];
            r.created = 1'b1;
            slot_count++;
            return r;
        endfunction

        function void note_input(vkit_pkg::vkit_in_t k);
            expected_results = {expected_results, intern_key(k)};
        endfunction

        function void check_result(vkit_pkg::vkit_out_t got);
            vkit_pkg::vkit_out_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item: handle %0d created %0b full %0b",
                             got.handle, got.created, got.table_full);
                return;
            end
            want = expected_results.pop_front();
            if (got.handle !== want.handle || got.created !== want.created ||
                got.table_full !== want.table_full) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch (exp/got): handle %0d/%0d created %0b/%0b full %0b/%0b",
                             want.handle, got.handle, want.created, got.created,
                             want.table_full, got.table_full);
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    vkit_pkg::vkit_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vkit_pkg::vkit_out_t m_data;

    intern_scoreboard board;
    bit          idle_enable = 1'b1;
    int unsigned rx_hold     = 0;
    int unsigned cycles      = 0;

    variant_key_interning_table_unit #(
        .CAPACITY(SLOTS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check on every handshake, stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (aresetn && idle_enable && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Valid stays high across back-to-back items; it only drops for an idle burst.
    task automatic send_item(input vkit_pkg::vkit_in_t k);
        s_valid <= 1'b1;
        s_data  <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(k);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    initial begin
        vkit_pkg::vkit_in_t         directed_keys[$];
        vkit_pkg::vkit_in_t         k;
        logic [vkit_pkg::KEY_W-1:0] bits;
        int                         n;
        int                         mode;
        int                         pick;
        int                         post_full;

        board = new;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes, one-field differences from the zero key, and repeats that hit.
        k = '0;
        directed_keys = {directed_keys, k, k};
        k = '1;
        directed_keys = {directed_keys, k, k};
        k = '0; k.technique_id  = '1;             directed_keys = {directed_keys, k};
        k = '0; k.definition_id = '1;             directed_keys = {directed_keys, k};
        k = '0; k.feature_hash  = '1;             directed_keys = {directed_keys, k};
        k = '0; k.phase_id      = '1;             directed_keys = {directed_keys, k};
        k = '0; k.tier_id       = '1;             directed_keys = {directed_keys, k};
        k = '0; k.tier_id       = 8'd1;           directed_keys = {directed_keys, k};
        k = '0; k.technique_id  = 32'h8000_0000;  directed_keys = {directed_keys, k};
        k = {vkit_pkg::KEY_W/2{2'b10}};           directed_keys = {directed_keys, k};
        k = {vkit_pkg::KEY_W/2{2'b01}};           directed_keys = {directed_keys, k};
        k = '0;                                   directed_keys = {directed_keys, k};
        k = '0; k.phase_id      = '1;             directed_keys = {directed_keys, k};
        k = '1;                                   directed_keys = {directed_keys, k};

        foreach (directed_keys[i])
            send_item(directed_keys[i]);

        // Mix of exact hits, single-bit near misses and fresh keys; runs on past
        // the point where the table fills so full-table hits and misses are seen.
        n = directed_keys.size();
        post_full = 0;
        while (n < ITEMS || post_full < FULL_ITEMS) begin
            idle_enable = !(n >= 150 && n < 200) && n < ITEMS - QUIET_TAIL;
            mode = $urandom_range(0, 99);
            if (board.slot_count > 0 && mode < 35) begin
                case ($urandom_range(0, 3))
                    0:       pick = 0;
                    1:       pick = board.slot_count - 1;
                    default: pick = $urandom_range(0, board.slot_count - 1);
                endcase
                k = board.slot_key[pick];
            end else if (board.slot_count > 0 && mode < 55) begin
                bits = board.slot_key[$urandom_range(0, board.slot_count - 1)];
                bits[$urandom_range(0, vkit_pkg::KEY_W - 1)] ^= 1'b1;
                k = bits;
            end else begin
                k.technique_id  = $urandom;
                k.definition_id = $urandom;
                k.feature_hash  = {$urandom, $urandom};
                k.phase_id      = 8'($urandom_range(0, 255));
                k.tier_id       = 8'($urandom_range(0, 255));
                if (mode >= 90)
                    k.technique_id = $urandom_range(0, 3);
            end
            if (board.slot_count == SLOTS)
                post_full++;
            send_item(k);
            n++;
        end
        s_valid <= 1'b0;
        idle_enable = 1'b0;

        while (board.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/vkit_pkg.sv
hw/rtl/vkit_ram.sv
hw/rtl/vkit_dp.sv
hw/rtl/vkit_ctrl.sv
hw/rtl/variant_key_interning_table_unit.sv
tb/tb_variant_key_interning_table_unit.sv
